// ===== hw/rtl/smadf_pkg.sv =====
// Package with the shared types and constants of the SPI master.
`default_nettype none
package smadf_pkg;

  localparam int FRAME_BITS = 16;
  localparam int WORD_BITS = 2 * FRAME_BITS;
  localparam int BIT_CNT_W = $clog2(FRAME_BITS);
  localparam int TICK_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_GAP = 1'b1;

  localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = TICK_W'(1);
  localparam logic [TICK_W-1:0] GAP_RESET = TICK_W'(10);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [FRAME_BITS-1:0] address;
    logic [FRAME_BITS-1:0] write_data;
    logic                  miso;
  } item_t;

  typedef struct packed {
    logic                  sck;
    logic                  mosi;
    logic                  chip_select_n;
    logic                  busy_res;
    logic [FRAME_BITS-1:0] read_data;
    logic                  done_res;
  } result_t;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_ADDR_HI = 7'b0000010,
    PH_ADDR_LO = 7'b0000100,
    PH_GAP     = 7'b0001000,
    PH_DATA_HI = 7'b0010000,
    PH_DATA_LO = 7'b0100000,
    PH_TAIL    = 7'b1000000
  } phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/smadf_in_if.sv =====
// Input channel interface: one tick item with command, address, data and MISO level.
`default_nettype none
interface smadf_in_if;
  import smadf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [FRAME_BITS-1:0] address;
  logic [FRAME_BITS-1:0] write_data;
  logic                  miso;

  modport source (output valid, output command, output address, output write_data,
                  output miso, input ready);
  modport sink (input valid, input command, input address, input write_data,
                input miso, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/smadf_out_if.sv =====
// Output channel interface: pin levels and status after each tick.
`default_nettype none
interface smadf_out_if;
  import smadf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  sck;
  logic                  mosi;
  logic                  chip_select_n;
  logic                  busy_res;
  logic [FRAME_BITS-1:0] read_data;
  logic                  done_res;

  modport source (output valid, output sck, output mosi, output chip_select_n,
                  output busy_res, output read_data, output done_res, input ready);
  modport sink (input valid, input sck, input mosi, input chip_select_n,
                input busy_res, input read_data, input done_res, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/smadf_front.sv =====
// Front end: classifies incoming items and holds them in a two-entry queue.
`default_nettype none
module smadf_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic [smadf_pkg::FRAME_BITS-1:0]  address,
  input  wire logic [smadf_pkg::FRAME_BITS-1:0]  write_data,
  input  wire logic                              miso,
  output logic                                   q_valid,
  output smadf_pkg::item_t                       q_item,
  input  wire logic                              q_pop
);
  import smadf_pkg::*;

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_IDX_W:0]   count;
  logic                 push;
  logic                 pop;
  item_t                classified;

  always_comb begin
    classified.address = address;
    classified.write_data = write_data;
    classified.miso = miso;
    case (command)
      CMD_WRITE: classified.op = OP_WRITE;
      CMD_READ:  classified.op = OP_READ;
      default:   classified.op = OP_TICK;
    endcase
  end

  assign in_ready = !rst && (count != (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/smadf_engine.sv =====
// Back end: SPI frame sequencer that advances one tick per item and registers the result.
`default_nettype none
module smadf_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [15:0]           half_period_ticks,
  input  wire logic [15:0]           gap_ticks,
  input  wire logic                  q_valid,
  input  wire smadf_pkg::item_t      q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output smadf_pkg::result_t         out_data
);
  import smadf_pkg::*;

  phase_t                phase, phase_next;
  logic [BIT_CNT_W-1:0]  bit_count, bit_count_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [WORD_BITS-1:0]  shift_word, shift_word_next;
  logic                  is_read, is_read_next;
  logic [FRAME_BITS-1:0] receive_word, receive_word_next;
  logic [FRAME_BITS-1:0] last_read, last_read_next;
  logic                  sck, sck_next;
  logic                  mosi, mosi_next;
  logic                  cs_n, cs_n_next;
  logic                  done;
  logic [TICK_W:0]       tick_inc;
  logic [TICK_W-1:0]     seg_len;
  logic [FRAME_BITS-1:0] start_addr;
  logic                  step;

  assign step = q_valid && (!out_valid || out_ready);
  assign q_pop = step;

  always_comb begin
    phase_next = phase;
    bit_count_next = bit_count;
    tick_count_next = tick_count;
    shift_word_next = shift_word;
    is_read_next = is_read;
    receive_word_next = receive_word;
    last_read_next = last_read;
    sck_next = sck;
    mosi_next = mosi;
    cs_n_next = cs_n;
    done = 1'b0;
    tick_inc = {1'b0, tick_count} + 1'b1;
    if (phase == PH_GAP) begin
      seg_len = gap_ticks;
    end else if (half_period_ticks == '0) begin
      seg_len = TICK_W'(1);
    end else begin
      seg_len = half_period_ticks;
    end
    start_addr = q_item.address;
    if (q_item.op == OP_READ) begin
      start_addr[FRAME_BITS-1] = 1'b1;
    end

    if (phase == PH_IDLE) begin
      if (q_item.op != OP_TICK) begin
        is_read_next = (q_item.op == OP_READ);
        shift_word_next = {start_addr, q_item.write_data};
        receive_word_next = '0;
        bit_count_next = BIT_CNT_W'(FRAME_BITS - 1);
        phase_next = PH_ADDR_HI;
        tick_count_next = '0;
        cs_n_next = 1'b0;
        mosi_next = start_addr[FRAME_BITS-1];
        sck_next = 1'b1;
      end
    end else if (tick_inc < {1'b0, seg_len}) begin
      tick_count_next = tick_inc[TICK_W-1:0];
    end else begin
      tick_count_next = '0;
      case (phase)
        PH_ADDR_HI: begin
          phase_next = PH_ADDR_LO;
          sck_next = 1'b0;
        end
        PH_ADDR_LO: begin
          shift_word_next = {shift_word[WORD_BITS-2:0], 1'b0};
          if (bit_count != '0) begin
            bit_count_next = bit_count - 1'b1;
            phase_next = PH_ADDR_HI;
            mosi_next = shift_word_next[WORD_BITS-1];
            sck_next = 1'b1;
          end else begin
            mosi_next = 1'b0;
            if (gap_ticks != '0) begin
              phase_next = PH_GAP;
            end else begin
              bit_count_next = BIT_CNT_W'(FRAME_BITS - 1);
              if (is_read) begin
                phase_next = PH_DATA_LO;
                sck_next = 1'b0;
                receive_word_next = {receive_word[FRAME_BITS-2:0], q_item.miso};
              end else begin
                phase_next = PH_DATA_HI;
                mosi_next = shift_word_next[WORD_BITS-1];
                sck_next = 1'b1;
              end
            end
          end
        end
        PH_GAP: begin
          bit_count_next = BIT_CNT_W'(FRAME_BITS - 1);
          if (is_read) begin
            phase_next = PH_DATA_LO;
            sck_next = 1'b0;
            receive_word_next = {receive_word[FRAME_BITS-2:0], q_item.miso};
          end else begin
            phase_next = PH_DATA_HI;
            mosi_next = shift_word[WORD_BITS-1];
            sck_next = 1'b1;
          end
        end
        PH_DATA_HI: begin
          if (!is_read) begin
            phase_next = PH_DATA_LO;
            sck_next = 1'b0;
          end else if (bit_count != '0) begin
            bit_count_next = bit_count - 1'b1;
            phase_next = PH_DATA_LO;
            sck_next = 1'b0;
            receive_word_next = {receive_word[FRAME_BITS-2:0], q_item.miso};
          end else begin
            phase_next = PH_TAIL;
            sck_next = 1'b0;
          end
        end
        PH_DATA_LO: begin
          if (is_read) begin
            phase_next = PH_DATA_HI;
            sck_next = 1'b1;
          end else begin
            shift_word_next = {shift_word[WORD_BITS-2:0], 1'b0};
            if (bit_count != '0) begin
              bit_count_next = bit_count - 1'b1;
              phase_next = PH_DATA_HI;
              mosi_next = shift_word_next[WORD_BITS-1];
              sck_next = 1'b1;
            end else begin
              phase_next = PH_IDLE;
              cs_n_next = 1'b1;
              sck_next = 1'b0;
              done = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          cs_n_next = 1'b1;
          sck_next = 1'b0;
          if (is_read) begin
            last_read_next = receive_word;
          end
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_count <= '0;
      tick_count <= '0;
      shift_word <= '0;
      is_read <= 1'b0;
      receive_word <= '0;
      last_read <= '0;
      sck <= 1'b0;
      mosi <= 1'b0;
      cs_n <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase <= phase_next;
        bit_count <= bit_count_next;
        tick_count <= tick_count_next;
        shift_word <= shift_word_next;
        is_read <= is_read_next;
        receive_word <= receive_word_next;
        last_read <= last_read_next;
        sck <= sck_next;
        mosi <= mosi_next;
        cs_n <= cs_n_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.sck <= sck_next;
      out_data.mosi <= mosi_next;
      out_data.chip_select_n <= cs_n_next;
      out_data.busy_res <= (phase_next != PH_IDLE);
      out_data.read_data <= last_read_next;
      out_data.done_res <= done;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/spi_master_addr_data_frame.sv =====
// Top level of the pin-level SPI master with address and data frames.
// An accepted input item is written into the two-entry queue, and its result is then
// registered in the output register, from which the result item can be taken.
// Throughput: one item per cycle unless the output side stalls.
// A two-entry queue and an output register let both sides stall independently.
// Reset is synchronous and active high; registers return to a half period of one
// tick and a gap of ten ticks, with the pins idle and the last read word zero.
`default_nettype none
module spi_master_addr_data_frame (
  input  wire logic    clk,
  input  wire logic    rst,
  smadf_in_if.sink     req,
  smadf_out_if.source  rsp,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire logic [15:0] cfg_data
);
  import smadf_pkg::*;

  logic [TICK_W-1:0] half_period_ticks;
  logic [TICK_W-1:0] gap_ticks;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;
  result_t           out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      gap_ticks <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        CFG_GAP:         gap_ticks <= cfg_data;
        default:         gap_ticks <= gap_ticks;
      endcase
    end
  end

  smadf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .command    (req.command),
    .address    (req.address),
    .write_data (req.write_data),
    .miso       (req.miso),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  smadf_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .half_period_ticks (half_period_ticks),
    .gap_ticks         (gap_ticks),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_data          (out_data)
  );

  assign rsp.sck = out_data.sck;
  assign rsp.mosi = out_data.mosi;
  assign rsp.chip_select_n = out_data.chip_select_n;
  assign rsp.busy_res = out_data.busy_res;
  assign rsp.read_data = out_data.read_data;
  assign rsp.done_res = out_data.done_res;
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the pin-level SPI master with address and data frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smadf_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 100;
  localparam int NUM_ROWS = 21;
  localparam int ITEMS_PER_PHASE = 20;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [FRAME_BITS-1:0] READ_FLAG = 16'h8000;

  localparam result_t PINS_IDLE = '{sck: 1'b0, mosi: 1'b0, chip_select_n: 1'b1,
                                    busy_res: 1'b0, read_data: 16'h0000, done_res: 1'b0};
  localparam result_t PINS_START = '{sck: 1'b1, mosi: 1'b1, chip_select_n: 1'b0,
                                     busy_res: 1'b1, read_data: 16'h0000, done_res: 1'b0};
  localparam result_t PINS_ADDR_LO = '{sck: 1'b0, mosi: 1'b1, chip_select_n: 1'b0,
                                       busy_res: 1'b1, read_data: 16'h0000, done_res: 1'b0};

  typedef struct {
    phase_t                ph;
    int unsigned           bits_left;
    int unsigned           ticks;
    logic [WORD_BITS-1:0]  frame;
    logic                  rd;
    logic [FRAME_BITS-1:0] rx;
    logic [FRAME_BITS-1:0] last_rx;
    logic                  sck;
    logic                  mosi;
    logic                  csn;
  } spi_model_t;

  typedef struct {
    bit                    is_cfg;
    logic                  cfg_idx;
    logic [1:0]            command;
    logic [FRAME_BITS-1:0] address;
    logic [FRAME_BITS-1:0] data;
    logic                  miso;
    int                    reps;
    bit                    typed;
    result_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  smadf_in_if req_ch ();
  smadf_out_if rsp_ch ();

  spi_master_addr_data_frame uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spi_model_t spi;
  logic [15:0] half_cfg;
  logic [15:0] gap_cfg;
  result_t expected_pins[$];
  int mismatch_count = 0;
  int report_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  stim_row_t stim_rows [NUM_ROWS];

  always #6 clk = ~clk;

  function automatic void spi_sample_bit(logic miso);
    spi.ph = PH_DATA_LO;
    spi.ticks = 0;
    spi.sck = 1'b0;
    spi.rx = {spi.rx[FRAME_BITS-2:0], miso};
  endfunction

  function automatic void spi_enter_data(logic miso);
    spi.bits_left = FRAME_BITS - 1;
    if (spi.rd) begin
      spi_sample_bit(miso);
    end else begin
      spi.ph = PH_DATA_HI;
      spi.ticks = 0;
      spi.mosi = spi.frame[WORD_BITS-1];
      spi.sck = 1'b1;
    end
  endfunction

  function automatic void spi_close_frame();
    spi.ph = PH_IDLE;
    spi.ticks = 0;
    spi.csn = 1'b1;
    spi.sck = 1'b0;
    if (spi.rd) begin
      spi.last_rx = spi.rx;
    end
  endfunction

  function automatic result_t spi_tick(logic [1:0] cmd, logic [FRAME_BITS-1:0] addr,
                                       logic [FRAME_BITS-1:0] wdata, logic miso);
    int unsigned seg_len;
    logic done;
    result_t r;
    done = 1'b0;
    if (spi.ph == PH_IDLE) begin
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
        spi.rd = (cmd == CMD_READ);
        spi.frame = {addr | (spi.rd ? READ_FLAG : 16'h0000), wdata};
        spi.rx = '0;
        spi.bits_left = FRAME_BITS - 1;
        spi.ph = PH_ADDR_HI;
        spi.ticks = 0;
        spi.csn = 1'b0;
        spi.mosi = spi.frame[WORD_BITS-1];
        spi.sck = 1'b1;
      end
    end else begin
      if (spi.ph == PH_GAP) begin
        seg_len = gap_cfg;
      end else begin
        seg_len = (half_cfg == 16'd0) ? 1 : half_cfg;
      end
      spi.ticks++;
      if (spi.ticks >= seg_len) begin
        case (spi.ph)
          PH_ADDR_HI: begin
            spi.ph = PH_ADDR_LO;
            spi.ticks = 0;
            spi.sck = 1'b0;
          end
          PH_ADDR_LO: begin
            spi.frame = spi.frame << 1;
            if (spi.bits_left != 0) begin
              spi.bits_left--;
              spi.ph = PH_ADDR_HI;
              spi.ticks = 0;
              spi.mosi = spi.frame[WORD_BITS-1];
              spi.sck = 1'b1;
            end else begin
              spi.mosi = 1'b0;
              if (gap_cfg == 16'd0) begin
                spi_enter_data(miso);
              end else begin
                spi.ph = PH_GAP;
                spi.ticks = 0;
              end
            end
          end
          PH_GAP: begin
            spi_enter_data(miso);
          end
          PH_DATA_HI: begin
            if (!spi.rd) begin
              spi.ph = PH_DATA_LO;
              spi.ticks = 0;
              spi.sck = 1'b0;
            end else if (spi.bits_left != 0) begin
              spi.bits_left--;
              spi_sample_bit(miso);
            end else begin
              spi.ph = PH_TAIL;
              spi.ticks = 0;
              spi.sck = 1'b0;
            end
          end
          PH_DATA_LO: begin
            if (spi.rd) begin
              spi.ph = PH_DATA_HI;
              spi.ticks = 0;
              spi.sck = 1'b1;
            end else begin
              spi.frame = spi.frame << 1;
              if (spi.bits_left != 0) begin
                spi.bits_left--;
                spi.ph = PH_DATA_HI;
                spi.ticks = 0;
                spi.mosi = spi.frame[WORD_BITS-1];
                spi.sck = 1'b1;
              end else begin
                spi_close_frame();
                done = 1'b1;
              end
            end
          end
          default: begin
            spi_close_frame();
            done = 1'b1;
          end
        endcase
      end
    end
    r.sck = spi.sck;
    r.mosi = spi.mosi;
    r.chip_select_n = spi.csn;
    r.busy_res = (spi.ph != PH_IDLE);
    r.read_data = spi.last_rx;
    r.done_res = done;
    return r;
  endfunction

  function automatic bit field_matches(string name, logic [15:0] want, logic [15:0] got);
    if (got === want) begin
      return 1'b1;
    end
    if (report_count < MAX_REPORTS) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
    report_count++;
    return 1'b0;
  endfunction

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_pins.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HALF_PERIOD) begin
      half_cfg = val;
    end else begin
      gap_cfg = val;
    end
  endtask

  task automatic offer_tick(logic [1:0] cmd, logic [FRAME_BITS-1:0] addr,
                            logic [FRAME_BITS-1:0] wdata, logic miso, bit typed,
                            result_t want);
    result_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.address <= addr;
    req_ch.write_data <= wdata;
    req_ch.miso <= miso;
    do @(posedge clk); while (!req_ch.ready);
    predicted = spi_tick(cmd, addr, wdata, miso);
    expected_pins.push_back(typed ? want : predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int hold_left;
    result_t want;
    bit ok;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (expected_pins.size() == 0) begin
          mismatch_count++;
          if (report_count < MAX_REPORTS) begin
            $display("%0t ns: result item with nothing expected", $time);
          end
          report_count++;
        end else begin
          want = expected_pins.pop_front();
          ok = field_matches("sck", want.sck, rsp_ch.sck)
             & field_matches("mosi", want.mosi, rsp_ch.mosi)
             & field_matches("chip_select_n", want.chip_select_n, rsp_ch.chip_select_n)
             & field_matches("busy_res", want.busy_res, rsp_ch.busy_res)
             & field_matches("read_data", want.read_data, rsp_ch.read_data)
             & field_matches("done_res", want.done_res, rsp_ch.done_res);
          if (!ok) begin
            mismatch_count++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("spi_master_addr_data_frame regression: fail");
    $finish;
  end

  initial begin
    logic [1:0] cmd;
    logic [FRAME_BITS-1:0] addr;
    logic [FRAME_BITS-1:0] wdata;
    int pick;
    stim_rows = '{
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b0, 1,  1'b1, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1,  1'b1, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_WRITE,   16'hFFFF, 16'h0000, 1'b0, 1,  1'b1, PINS_START},
      '{1'b0, CFG_HALF_PERIOD, OP_READ,    16'h0000, 16'hFFFF, 1'b1, 1,  1'b1, PINS_ADDR_LO},
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b0, 80, 1'b0, PINS_IDLE},
      '{1'b1, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b1, CFG_GAP,         OP_TICK,    16'h0000, 16'h0000, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_READ,    16'h0000, 16'h0000, 1'b1, 1,  1'b1, PINS_START},
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b1, 70, 1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_WRITE,   16'h0000, 16'hFFFF, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_WRITE,   16'hFFFF, 16'h0000, 1'b0, 70, 1'b0, PINS_IDLE},
      '{1'b1, CFG_GAP,         OP_TICK,    16'h0000, 16'hFFFF, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b1, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'hFFFF, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_WRITE,   16'h5A5A, 16'hA5A5, 1'b1, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b0, 8,  1'b0, PINS_IDLE},
      '{1'b1, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0001, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b1, 70, 1'b0, PINS_IDLE},
      '{1'b1, CFG_GAP,         OP_TICK,    16'h0000, 16'h0000, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_READ,    16'hFFFF, 16'hFFFF, 1'b1, 70, 1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_READ,    16'h7FFF, 16'h0000, 1'b0, 1,  1'b0, PINS_IDLE},
      '{1'b0, CFG_HALF_PERIOD, OP_TICK,    16'h0000, 16'h0000, 1'b0, 70, 1'b0, PINS_IDLE}
    };
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.command <= OP_TICK;
    req_ch.address <= '0;
    req_ch.write_data <= '0;
    req_ch.miso <= 1'b0;
    spi = '{PH_IDLE, 0, 0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1};
    half_cfg = HALF_PERIOD_RESET;
    gap_cfg = GAP_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 30;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_reg(stim_rows[i].cfg_idx, stim_rows[i].data);
      end else begin
        repeat (stim_rows[i].reps) begin
          offer_tick(stim_rows[i].command, stim_rows[i].address, stim_rows[i].data,
                     stim_rows[i].miso, stim_rows[i].typed, stim_rows[i].want);
        end
      end
    end

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_HALF_PERIOD, 16'($urandom_range(3)));
      write_reg(CFG_GAP, 16'($urandom_range(4)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase_no == 0 && n == 6) begin
          hold_req = 300;
        end
        if (phase_no == 1 && n == 10) begin
          drain_results();
        end
        if (n == 14) begin
          write_reg(CFG_HALF_PERIOD, 16'($urandom_range(3)));
          write_reg(CFG_GAP, 16'($urandom_range(3)));
        end
        pick = $urandom_range(99);
        if (spi.ph == PH_IDLE && pick < 75) begin
          cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
        end else if (spi.ph == PH_IDLE && pick < 88) begin
          cmd = OP_TICK;
        end else if (spi.ph == PH_IDLE) begin
          cmd = CMD_UNUSED;
        end else begin
          cmd = 2'($urandom_range(3));
        end
        addr = 16'($urandom_range(16'hFFFF));
        wdata = 16'($urandom_range(16'hFFFF));
        offer_tick(cmd, addr, wdata, 1'($urandom_range(1)), 1'b0, PINS_IDLE);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pins.size() == 0) begin
      $display("spi_master_addr_data_frame regression: pass");
    end else begin
      $display("spi_master_addr_data_frame regression: fail");
    end
    $finish;
  end

endmodule
